[rtl/flfnv_pkg.sv]
// Shared types, constants and arithmetic helpers for the four-lane FNV index hash.
`default_nettype none

package flfnv_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
  localparam logic [63:0] TAIL_SEED   = 64'hcbf29ce484222325;
  localparam logic [63:0] LANE_SEED_0 = 64'd1469598103934665603;
  localparam logic [63:0] LANE_SEED_1 = 64'd1099511628211;
  localparam logic [63:0] LANE_SEED_2 = 64'd14695981039346656037;
  localparam logic [63:0] LANE_SEED_3 = 64'd1234567890123456789;

  localparam logic [3:0][63:0] LANE_SEEDS = {LANE_SEED_3, LANE_SEED_2, LANE_SEED_1, LANE_SEED_0};

  // Low nine bits of the prime; the prime is two to the fortieth plus this value.
  localparam logic [8:0] PRIME_LOW = 9'd435;

  typedef struct packed {
    logic [31:0] index_value;
    logic        has_element;
    logic        last;
  } word_t;

  // Multiplication by the prime modulo two to the sixty-fourth, as a shift and a narrow product.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [72:0] p;
    p = x * PRIME_LOW;
    return (x << 40) + p[63:0];
  endfunction

  // Rotation left by seven times the lane number.
  function automatic logic [63:0] lane_rotl(input logic [63:0] v, input logic [1:0] k);
    logic [63:0] r;
    case (k)
      2'd0: r = v;
      2'd1: r = {v[56:0], v[63:57]};
      2'd2: r = {v[49:0], v[63:50]};
      2'd3: r = {v[42:0], v[63:43]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/flfnv_front.sv]
// Input side: accepts words, drops those that carry nothing and queues the rest.
`default_nettype none

module flfnv_front #(
  parameter int QUEUE_DEPTH = flfnv_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [31:0]      index_value,
  input  wire logic             has_element,
  input  wire logic             last,
  output logic                  q_valid,
  output flfnv_pkg::word_t      q_word,
  input  wire logic             q_ready
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  flfnv_pkg::word_t slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    used;
  logic             push;
  logic             pop;

  assign in_ready = !rst && (used != CW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && (has_element || last);
  assign q_valid  = (used != '0);
  assign q_word   = slots[rd_ptr];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        used <= used + CW'(1);
      end else if (pop && !push) begin
        used <= used - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{index_value: index_value, has_element: has_element, last: last};
    end
  end

endmodule

`default_nettype wire

[rtl/flfnv_back.sv]
// Execution side: lane updates per group of four and the finalisation over the tail, lane and emit states.
`default_nettype none

module flfnv_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire flfnv_pkg::word_t  q_word,
  output logic                   q_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [63:0]            hash_value
);

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_TAIL = 4'b0010,
    ST_LANE = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t      state;
  logic [63:0] lanes [4];
  logic [31:0] pend [3];
  logic [1:0]  fill;
  logic [1:0]  fill_next;
  logic [1:0]  step;
  logic [63:0] count;
  logic [63:0] h;
  logic        pop;
  logic        take;
  logic        load;

  assign q_ready = (state == ST_RUN);
  assign pop     = q_valid && q_ready;
  assign take    = pop && q_word.has_element;
  assign load    = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    if (take) begin
      fill_next = (fill == 2'd3) ? 2'd0 : fill + 2'd1;
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      fill      <= 2'd0;
      count     <= 64'd0;
      out_valid <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        lanes[k] <= flfnv_pkg::LANE_SEEDS[k];
      end
    end else begin
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (fill == 2'd3) begin
          for (int k = 0; k < 3; k++) begin
            lanes[k] <= flfnv_pkg::fnv_mul(lanes[k] ^ {32'd0, pend[k]});
          end
          lanes[3] <= flfnv_pkg::fnv_mul(lanes[3] ^ {32'd0, q_word.index_value});
        end
        fill  <= fill_next;
        count <= count + 64'd1;
      end
      case (state)
        ST_RUN: begin
          if (pop && q_word.last) begin
            state <= (fill_next == 2'd0) ? ST_LANE : ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (step + 2'd1 == fill) begin
            state <= ST_LANE;
          end
        end
        ST_LANE: begin
          if (step == 2'd3) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            fill      <= 2'd0;
            count     <= 64'd0;
            state     <= ST_RUN;
            for (int k = 0; k < 4; k++) begin
              lanes[k] <= flfnv_pkg::LANE_SEEDS[k];
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_RUN: begin
        if (take && fill != 2'd3) begin
          pend[fill] <= q_word.index_value;
        end
        h    <= flfnv_pkg::TAIL_SEED;
        step <= 2'd0;
      end
      ST_TAIL: begin
        h    <= flfnv_pkg::fnv_mul(h ^ {32'd0, pend[step]});
        step <= (step + 2'd1 == fill) ? 2'd0 : step + 2'd1;
      end
      ST_LANE: begin
        h    <= flfnv_pkg::fnv_mul(h ^ flfnv_pkg::lane_rotl(lanes[step], step));
        step <= step + 2'd1;
      end
      ST_EMIT: begin
        if (load) begin
          hash_value <= h ^ flfnv_pkg::fnv_mul(count);
        end
      end
      default: begin
        step <= 2'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/four_lane_fnv_index_hash_core.sv]
// Top level of the four-lane FNV-1a index hash.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | index_value, has_element, last
//  out     | output    | out_valid/out_ready| hash_value
//
// Element words are taken at one a cycle while the queue has room. A word with last then
// passes the back end through the tail state, one multiply by the prime for each of the
// P (0 to 3) leftover elements, the lane state, one per lane, and the emit state.
// Words carrying neither an element nor last are accepted and discarded.
// Reset is synchronous and clears the queue, the lanes and the result valid flag.
// A stalled result holds the back end in its final step; the queue keeps filling meanwhile.
`default_nettype none

module four_lane_fnv_index_hash_core #(
  parameter int QUEUE_DEPTH = flfnv_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] index_value,
  input  wire logic        has_element,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      hash_value
);

  logic             q_valid;
  logic             q_ready;
  flfnv_pkg::word_t q_word;

  flfnv_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .index_value (index_value),
    .has_element (has_element),
    .last        (last),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_ready     (q_ready)
  );

  flfnv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_ready    (q_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

`default_nettype wire

[rtl/flfnv_checker.sv]
// Port-level checks for the four-lane FNV index hash, bound to the top level.
`default_nettype none

module flfnv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hash_value))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |-> !in_ready ##1 !out_valid)
    else $error("block not idle around reset");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst) && !$past(rst, 2) && !$past(rst, 3))
    else $error("result word appeared too soon after reset");

endmodule

bind four_lane_fnv_index_hash_core flfnv_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hash_value (hash_value)
);

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the four-lane FNV-1a index hash core.
`timescale 1ns / 1ps

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] index_value = 32'd0;
  logic        has_element = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] hash_value;

  four_lane_fnv_index_hash_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .index_value (index_value),
    .has_element (has_element),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash_value  (hash_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  localparam flfnv_pkg::word_t DIRECTED_WORDS [25] = '{
    '{32'h00000000, 1'b0, 1'b1},
    '{32'hffffffff, 1'b1, 1'b1},
    '{32'h00000000, 1'b1, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0},
    '{32'h12345678, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1},
    '{32'hffffffff, 1'b1, 1'b0},
    '{32'hffffffff, 1'b1, 1'b0},
    '{32'hffffffff, 1'b1, 1'b0},
    '{32'hffffffff, 1'b0, 1'b1},
    '{32'ha5a5a5a5, 1'b1, 1'b0},
    '{32'h5a5a5a5a, 1'b1, 1'b0},
    '{32'h80000000, 1'b1, 1'b0},
    '{32'h00000001, 1'b1, 1'b1},
    '{32'hdeadbeef, 1'b1, 1'b0},
    '{32'h00000000, 1'b1, 1'b0},
    '{32'hffffffff, 1'b1, 1'b0},
    '{32'h7fffffff, 1'b1, 1'b0},
    '{32'h00000000, 1'b1, 1'b1},
    '{32'h00000000, 1'b0, 1'b1},
    '{32'h0f0f0f0f, 1'b1, 1'b0},
    '{32'hf0f0f0f0, 1'b1, 1'b0},
    '{32'h00010000, 1'b1, 1'b0},
    '{32'hfffffffe, 1'b0, 1'b0},
    '{32'hffffffff, 1'b1, 1'b1}
  };

  logic [63:0] lane_acc [4];
  logic [31:0] held_elem [3];
  int unsigned held_fill;
  logic [63:0] elem_count;
  logic [63:0] expected_hashes [$];
  logic [63:0] want_hash;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int messages_sent = 0;
  int hashes_checked = 0;
  int drain_cycles;

  function automatic logic [63:0] mix(input logic [63:0] acc, input logic [31:0] e);
    return (acc ^ {32'd0, e}) * flfnv_pkg::FNV_PRIME;
  endfunction

  function automatic logic [63:0] rotate_left(input logic [63:0] v, input int r);
    if (r == 0) return v;
    return (v << r) | (v >> (64 - r));
  endfunction

  task automatic clear_fingerprint();
    lane_acc[0] = flfnv_pkg::LANE_SEED_0;
    lane_acc[1] = flfnv_pkg::LANE_SEED_1;
    lane_acc[2] = flfnv_pkg::LANE_SEED_2;
    lane_acc[3] = flfnv_pkg::LANE_SEED_3;
    held_fill = 0;
    elem_count = 64'd0;
  endtask

  task automatic absorb_word(input logic [31:0] v, input logic h, input logic l);
    logic [63:0] acc;
    if (h) begin
      if (held_fill == 3) begin
        lane_acc[0] = mix(lane_acc[0], held_elem[0]);
        lane_acc[1] = mix(lane_acc[1], held_elem[1]);
        lane_acc[2] = mix(lane_acc[2], held_elem[2]);
        lane_acc[3] = mix(lane_acc[3], v);
        held_fill = 0;
      end else begin
        held_elem[held_fill] = v;
        held_fill++;
      end
      elem_count = elem_count + 64'd1;
    end
    if (l) begin
      acc = flfnv_pkg::TAIL_SEED;
      for (int k = 0; k < held_fill; k++) acc = mix(acc, held_elem[k]);
      for (int k = 0; k < 4; k++)
        acc = (acc ^ rotate_left(lane_acc[k], 7 * k)) * flfnv_pkg::FNV_PRIME;
      acc = acc ^ (elem_count * flfnv_pkg::FNV_PRIME);
      expected_hashes.push_back(acc);
      clear_fingerprint();
    end
  endtask

  task automatic send_word(input logic [31:0] v, input logic h, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    index_value <= v;
    has_element <= h;
    last        <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_word(v, h, l);
    if (h || l) words_sent++;
  endtask

  task automatic send_message(input int n);
    bit close_on_elem;
    close_on_elem = (n > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_word($urandom, 1'b0, 1'b0);
      send_word($urandom_range(15) == 0 ? 32'hffffffff : $urandom, 1'b1,
                close_on_elem && (i == n - 1));
    end
    if (!close_on_elem) send_word($urandom, 1'b0, 1'b1);
    messages_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hashes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $error("hash_value arrived with nothing expected: actual %h", hash_value);
        errors++;
      end else begin
        want_hash = expected_hashes.pop_front();
        if (hash_value !== want_hash) begin
          $error("hash_value mismatch: expected %h, actual %h", want_hash, hash_value);
          errors++;
        end
        hashes_checked++;
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    clear_fingerprint();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        for (int r = 0; r < $size(DIRECTED_WORDS); r++)
          send_word(DIRECTED_WORDS[r].index_value, DIRECTED_WORDS[r].has_element,
                    DIRECTED_WORDS[r].last);
      end
      // A long output stall lets the queue fill and push back on the input.
      if (phase == 1) hold_cycles = 200;
      while (words_sent < 300 * (phase + 1))
        send_message($urandom_range(9) == 0 ? $urandom_range(48, 10) : $urandom_range(9));
      wait_for_results();
    end
    drain_cycles = 0;
    while (expected_hashes.size() != 0 && drain_cycles < 100000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (expected_hashes.size() != 0) begin
      $error("%0d expected hash_value results never arrived", expected_hashes.size());
      errors++;
    end
    $display("Ran %0d messages over %0d element and closing words; %0d fingerprints checked.",
             messages_sent, words_sent, hashes_checked);
    $display("Idling was mixed on both sides, with one long output stall and full drains.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/flfnv_pkg.sv
rtl/flfnv_front.sv
rtl/flfnv_back.sv
rtl/four_lane_fnv_index_hash_core.sv
rtl/flfnv_checker.sv
sim/testbench.sv
